// File: src/tlf_pkg.sv
// Shared constants and codes of the tilemap layer tile fetch.
`default_nettype none
package tlf_pkg;

  localparam int MAP_DEPTH = 16384;
  localparam int TILE_IDS  = 4096;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int TILE_AW   = $clog2(TILE_IDS);

  localparam int TILE_W    = 12;
  localparam int ADDR_W    = 14;
  localparam int POS_W     = 5;
  localparam int MODE_W    = 2;
  localparam int FUNC_W    = 2;
  localparam int SCR_W     = 10;
  localparam int SCROLL_W  = 16;
  localparam int PAR_W     = 5;
  localparam int PROD_W    = SCROLL_W + PAR_W;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int WIDTH_W   = 15;
  localparam int COUNT_W   = 13;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [FUNC_W-1:0] FUNC_MAP_WR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_XLAT_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OPAQUE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MASKED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLEND   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SCROLL_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MUL_X      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIV_X      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MUL_Y      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIV_Y      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TILE_COUNT = 3'd7;

endpackage
`default_nettype wire

// File: src/tlf_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module tlf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: src/tlf_div.sv
// Restoring divider, one quotient bit per cycle, for the parallax origin.
`default_nettype none
module tlf_div
  import tlf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [PAR_W-1:0]  divisor,
  output logic                   busy,
  output logic      [PROD_W-1:0] quotient
);

  logic [PAR_W-1:0] rem;
  logic [PAR_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic [PAR_W:0]   sh;
  logic [PAR_W:0]   diff;
  logic             fits;

  always_comb begin
    sh   = {rem, quotient[PROD_W-1]};
    diff = sh - {1'b0, dreg};
    fits = sh >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      quotient <= '0;
      cnt      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      quotient <= dividend;
      rem      <= '0;
      dreg     <= divisor;
      cnt      <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[PAR_W-1:0] : sh[PAR_W-1:0];
      quotient <= {quotient[PROD_W-2:0], fits};
      cnt      <= cnt + 1'b1;
      if (cnt == CNT_W'(PROD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/tile_layer_fetch_parallax.sv
// Top level of the tilemap layer tile fetch with parallax scrolling.
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  item     | item_valid, item_stall, func, address, value,  | in
//           | row, col, draw_mode                            |
//  result   | result_valid, result_stall, screen_x,          | out
//           | screen_y, tile_number, draw, blend             |
//  config   | cfg_we, cfg_index, cfg_data                    | in
//
// One item enters per cycle while item_stall is low; a fetch result passes stages v0 to v4 and the output registers.
// The map store and translation table are each one single-port RAM read once per fetch item.
// A write to a scroll, multiplier or divisor register starts the origin dividers,
// which hold item_stall high until both quotients are done; reset leaves the origin at zero.
// A stalled result freezes the whole pipeline, and item_stall follows it.
`default_nettype none
module tile_layer_fetch_parallax
  import tlf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [REG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic [ADDR_W-1:0]       address,
  input  wire logic [TILE_W-1:0]       value,
  input  wire logic [POS_W-1:0]        row,
  input  wire logic [POS_W-1:0]        col,
  input  wire logic [MODE_W-1:0]       draw_mode,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic signed [SCR_W-1:0]      screen_x,
  output logic signed [SCR_W-1:0]      screen_y,
  output logic        [TILE_W-1:0]     tile_number,
  output logic                         draw,
  output logic        [MODE_W-1:0]     blend
);

  logic [SCROLL_W-1:0] scroll_x, scroll_y;
  logic [PAR_W-1:0]    mul_x, div_x, mul_y, div_y;
  logic [WIDTH_W-1:0]  map_width;
  logic [COUNT_W-1:0]  tile_count;
  logic                pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x   <= '0;
      scroll_y   <= '0;
      mul_x      <= PAR_W'(1);
      div_x      <= PAR_W'(1);
      mul_y      <= PAR_W'(1);
      div_y      <= PAR_W'(1);
      map_width  <= WIDTH_W'(128);
      tile_count <= COUNT_W'(4096);
      pending    <= 1'b0;
    end else begin
      pending <= cfg_we && (cfg_index <= REG_DIV_Y);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCROLL_X:   scroll_x   <= cfg_data;
          REG_SCROLL_Y:   scroll_y   <= cfg_data;
          REG_MUL_X:      mul_x      <= cfg_data[PAR_W-1:0];
          REG_DIV_X:      div_x      <= cfg_data[PAR_W-1:0];
          REG_MUL_Y:      mul_y      <= cfg_data[PAR_W-1:0];
          REG_DIV_Y:      div_y      <= cfg_data[PAR_W-1:0];
          REG_MAP_WIDTH:  map_width  <= cfg_data[WIDTH_W-1:0];
          REG_TILE_COUNT: tile_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  logic [PROD_W-1:0] prod_x, prod_y, ox, oy;
  logic [PAR_W-1:0]  dsr_x, dsr_y;
  logic              busy_x, busy_y;

  always_comb begin
    prod_x = PROD_W'(scroll_x) * PROD_W'(mul_x);
    prod_y = PROD_W'(scroll_y) * PROD_W'(mul_y);
    dsr_x  = (div_x == '0) ? PAR_W'(1) : div_x;
    dsr_y  = (div_y == '0) ? PAR_W'(1) : div_y;
  end

  tlf_div u_div_x (
    .clk(clk), .rst(rst), .start(pending), .dividend(prod_x), .divisor(dsr_x),
    .busy(busy_x), .quotient(ox)
  );

  tlf_div u_div_y (
    .clk(clk), .rst(rst), .start(pending), .dividend(prod_y), .divisor(dsr_y),
    .busy(busy_y), .quotient(oy)
  );

  logic advance, accept;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance || pending || busy_x || busy_y;
  assign accept     = item_valid && !item_stall;

  // Pipeline registers.
  logic                v0, v1, v2, v3, v4;
  logic [FUNC_W-1:0]   func0, func1, func2, func3, func4;
  logic [ADDR_W-1:0]   addr0, addr1, addr2, addr3;
  logic [TILE_W-1:0]   value0, value1, value2, value3;
  logic [POS_W-1:0]    row0, col0;
  logic [MODE_W-1:0]   mode0, blend1, blend2, blend3, blend4;
  logic [MAP_AW-1:0]   yterm1, xterm1, xterm2, prod2;
  logic [SCR_W-1:0]    sx1, sx2, sx3, sx4, sy1, sy2, sy3, sy4;

  logic [MAP_AW-1:0]   yterm_next, xterm_next, prod_next;
  logic [SCR_W-1:0]    sx_next, sy_next;
  logic [MODE_W-1:0]   blend_next;
  logic [2*MAP_AW-1:0] prod_full;

  always_comb begin
    yterm_next = oy[MAP_AW+3:4] + MAP_AW'(row0);
    xterm_next = ox[MAP_AW+3:4] + MAP_AW'(col0);
    sx_next    = {1'b0, col0, 4'b0000} - SCR_W'(ox[3:0]);
    sy_next    = {1'b0, row0, 4'b0000} - SCR_W'(oy[3:0]);
    blend_next = (mode0 == MODE_SPARE) ? MODE_MASKED : mode0;
    prod_full  = yterm1 * map_width[MAP_AW-1:0];
    prod_next  = prod_full[MAP_AW-1:0];
  end

  logic                map_we, map_re, xl_we, xl_re;
  logic [MAP_AW-1:0]   map_addr;
  logic [TILE_AW-1:0]  xl_addr;
  logic [TILE_W-1:0]   map_q, tile;

  always_comb begin
    map_we   = advance && v2 && (func2 == FUNC_MAP_WR);
    map_re   = advance && v2 && (func2 == FUNC_FETCH);
    map_addr = (func2 == FUNC_MAP_WR) ? addr2[MAP_AW-1:0] : prod2 + xterm2;
    xl_we    = advance && v3 && (func3 == FUNC_XLAT_WR);
    xl_re    = advance && v3 && (func3 == FUNC_FETCH);
    xl_addr  = (func3 == FUNC_XLAT_WR) ? addr3[TILE_AW-1:0] : map_q[TILE_AW-1:0];
  end

  tlf_ram #(.WIDTH(TILE_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .re(map_re), .addr(map_addr), .wdata(value2), .rdata(map_q)
  );

  tlf_ram #(.WIDTH(TILE_W), .DEPTH(TILE_IDS)) u_xlat (
    .clk(clk), .we(xl_we), .re(xl_re), .addr(xl_addr), .wdata(value3), .rdata(tile)
  );

  logic [TILE_W-1:0] tile_clamped;

  always_comb begin
    tile_clamped = ({1'b0, tile} >= tile_count) ? '0 : tile;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      result_valid <= v4 && (func4 == FUNC_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      func0  <= func;
      addr0  <= address;
      value0 <= value;
      row0   <= row;
      col0   <= col;
      mode0  <= draw_mode;

      func1  <= func0;
      addr1  <= addr0;
      value1 <= value0;
      yterm1 <= yterm_next;
      xterm1 <= xterm_next;
      sx1    <= sx_next;
      sy1    <= sy_next;
      blend1 <= blend_next;

      func2  <= func1;
      addr2  <= addr1;
      value2 <= value1;
      prod2  <= prod_next;
      xterm2 <= xterm1;
      sx2    <= sx1;
      sy2    <= sy1;
      blend2 <= blend1;

      func3  <= func2;
      addr3  <= addr2;
      value3 <= value2;
      sx3    <= sx2;
      sy3    <= sy2;
      blend3 <= blend2;

      func4  <= func3;
      sx4    <= sx3;
      sy4    <= sy3;
      blend4 <= blend3;

      screen_x    <= sx4;
      screen_y    <= sy4;
      tile_number <= tile_clamped;
      draw        <= (blend4 == MODE_OPAQUE) || (tile_clamped != '0);
      blend       <= blend4;
    end
  end

  a_no_transfer_during_divide: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |-> (!busy_x && !busy_y && !pending))
    else $error("Item transferred while the origin was being recomputed.");

  a_origin_write_stalls: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index <= REG_DIV_Y) |=> item_stall)
    else $error("Origin register write did not stall the item channel.");

  a_tile_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (tile_number == '0 || {1'b0, tile_number} < tile_count))
    else $error("Result tile number not clamped to the tile count.");

  a_skip_only_blank: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !draw) |-> (tile_number == '0 && blend != MODE_OPAQUE))
    else $error("Skipped a tile that should have been drawn.");

endmodule
`default_nettype wire
